// File: design/rrp_pkg.sv
// Package of the rectangle raster painter: widths, codes, and the
// command/status structs shared by the controller and the datapath.
// Depends on nothing.
package rrp_pkg;

  // Canvas geometry
  localparam int MAX_SIDE = 256;
  localparam int SIDE_W   = $clog2(MAX_SIDE);       // row/column index width
  localparam int SIZE_W   = SIDE_W + 1;             // size register width
  localparam int ADDR_W   = 2 * SIDE_W;             // pixel store address

  // Fixed point
  localparam int COORD_W  = 20;                     // Q12.8 field width
  localparam int FRAC_W   = 8;
  localparam int EXT_W    = COORD_W + 3;            // room for sums and edge offsets
  localparam int Q_ONE    = 256;

  // Field widths
  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 9;
  localparam int IN_W     = 112;
  localparam int OUT_W    = 16;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

  // Shape type characters
  localparam logic [CHAR_W-1:0] CHAR_OUTLINE = 8'h72;  // 'r'
  localparam logic [CHAR_W-1:0] CHAR_FILLED  = 8'h52;  // 'R'

  // Reset values of the registers
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);
  localparam logic [CHAR_W-1:0] BG_RESET   = 8'd32;

  typedef struct packed {
    logic load;    // capture the accepted request
    logic sweep;   // visit one pixel and advance
    logic finish;  // move the result into the output register
  } rrp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              empty;       // canvas has no pixels
    logic              invalid;     // draw request is bad
    logic              sweep_last;  // current pixel is the last one
    logic              out_free;    // output register can take a result
  } rrp_stat_t;

endpackage

// File: design/rrp_ctrl.sv
// Controller of the rectangle raster painter: sequences accept, decode,
// pixel sweep and result hand-off. Depends on rrp_pkg.
module rrp_ctrl
  import rrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  rrp_stat_t stat,
  output rrp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.kind)
          KIND_CLEAR: state_next = stat.empty ? ST_DONE : ST_SWEEP;
          KIND_DRAW:  state_next = (stat.invalid || stat.empty) ? ST_DONE : ST_SWEEP;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/rrp_datapath.sv
// Datapath of the rectangle raster painter: configuration registers, request
// registers, sweep counters, coverage test, pixel store and output register.
// Depends on rrp_pkg.
module rrp_datapath
  import rrp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [KIND_W-1:0]    s_tuser,
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,
  input  rrp_cmd_t             cmd,
  output rrp_stat_t            stat
);

  // Configuration registers
  logic [SIZE_W-1:0] canvas_width;
  logic [SIZE_W-1:0] canvas_height;
  logic [CHAR_W-1:0] background_char;

  // Clamped canvas size
  logic [SIZE_W-1:0] cols;
  logic [SIZE_W-1:0] rows;

  // Request registers
  logic [KIND_W-1:0]       kind;
  logic                    outline;
  logic                    invalid;
  logic [CHAR_W-1:0]       paint_char;
  logic [SIDE_W-1:0]       read_row;
  logic [SIDE_W-1:0]       read_col;
  logic signed [EXT_W-1:0] x_lo, x_lo1, x_hi, x_hi1;
  logic signed [EXT_W-1:0] y_lo, y_lo1, y_hi, y_hi1;

  // Unpacked input fields
  logic [CHAR_W-1:0]        in_type;
  logic signed [EXT_W-1:0]  in_x, in_y, in_w, in_h;
  logic signed [EXT_W-1:0]  in_xe, in_ye;

  // Sweep counters and pixel test
  logic [SIDE_W-1:0]       row;
  logic [SIDE_W-1:0]       col;
  logic                    col_last;
  logic                    row_last;
  logic signed [EXT_W-1:0] px, py;
  logic                    in_rect, on_edge, paint_en;

  // Pixel store
  logic [CHAR_W-1:0] mem [0:MAX_SIDE*MAX_SIDE-1];
  logic [CHAR_W-1:0] rd_data;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [CHAR_W-1:0] wr_data;

  // Result
  logic              read_out;
  logic [STAT_W-1:0] res_status;
  logic [CHAR_W-1:0] res_pixel;
  logic [STAT_W-1:0] out_status;
  logic [CHAR_W-1:0] out_pixel;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= SIZE_RESET;
      canvas_height   <= SIZE_RESET;
      background_char <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  canvas_width    <= cfg_data;
        REG_HEIGHT: canvas_height   <= cfg_data;
        REG_BG:     background_char <= cfg_data[CHAR_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp sizes to the store side
  assign cols = (canvas_width  > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : canvas_width;
  assign rows = (canvas_height > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : canvas_height;

  // Unpack and sign-extend the request fields
  assign in_type = s_tdata[7:0];
  assign in_x    = EXT_W'($signed(s_tdata[27:8]));
  assign in_y    = EXT_W'($signed(s_tdata[47:28]));
  assign in_w    = EXT_W'($signed(s_tdata[67:48]));
  assign in_h    = EXT_W'($signed(s_tdata[87:68]));
  assign in_xe   = in_x + in_w;
  assign in_ye   = in_y + in_h;

  // Capture the request and its edge bounds
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind       <= s_tuser;
      outline    <= (in_type == CHAR_OUTLINE);
      invalid    <= (in_w <= 0) || (in_h <= 0) ||
                    !((in_type == CHAR_OUTLINE) || (in_type == CHAR_FILLED));
      paint_char <= s_tdata[95:88];
      read_row   <= s_tdata[103:96];
      read_col   <= s_tdata[111:104];
      x_lo       <= in_x;
      x_lo1      <= in_x + EXT_W'(Q_ONE);
      x_hi       <= in_xe;
      x_hi1      <= in_xe - EXT_W'(Q_ONE);
      y_lo       <= in_y;
      y_lo1      <= in_y + EXT_W'(Q_ONE);
      y_hi       <= in_ye;
      y_hi1      <= in_ye - EXT_W'(Q_ONE);
    end
  end

  // Advance the sweep counters, column first
  assign col_last = ({1'b0, col} == cols - SIZE_W'(1));
  assign row_last = ({1'b0, row} == rows - SIZE_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row <= '0;
      col <= '0;
    end else if (cmd.sweep) begin
      if (col_last) begin
        col <= '0;
        row <= row + SIDE_W'(1);
      end else begin
        col <= col + SIDE_W'(1);
      end
    end
  end

  // Coverage test of the current pixel
  assign px = $signed({{(EXT_W-SIDE_W-FRAC_W){1'b0}}, col, {FRAC_W{1'b0}}});
  assign py = $signed({{(EXT_W-SIDE_W-FRAC_W){1'b0}}, row, {FRAC_W{1'b0}}});

  assign in_rect  = !(px < x_lo) && !(x_hi < px) && !(py < y_lo) && !(y_hi < py);
  assign on_edge  = (px < x_lo1) || (x_hi1 < px) || (py < y_lo1) || (y_hi1 < py);
  assign paint_en = in_rect && (!outline || on_edge);

  // Pixel store: one write, one registered read
  assign we      = cmd.sweep && ((kind == KIND_CLEAR) || paint_en);
  assign wr_addr = {row, col};
  assign wr_data = (kind == KIND_CLEAR) ? background_char : paint_char;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[{read_row, read_col}];
  end

  // Form the result
  assign read_out = ({1'b0, read_row} >= rows) || ({1'b0, read_col} >= cols);

  always_comb begin
    res_status = STAT_OK;
    res_pixel  = '0;
    case (kind)
      KIND_DRAW: begin
        if (invalid) begin
          res_status = STAT_BAD;
        end
      end
      KIND_READ: begin
        if (read_out) begin
          res_status = STAT_OUTSIDE;
        end else begin
          res_pixel = rd_data;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= res_status;
      out_pixel  <= res_pixel;
    end
  end

  assign m_tdata = {{(OUT_W-STAT_W-CHAR_W){1'b0}}, out_pixel, out_status};

  // Status to the controller
  assign stat.kind       = kind;
  assign stat.empty      = (cols == '0) || (rows == '0);
  assign stat.invalid    = invalid;
  assign stat.sweep_last = col_last && row_last;
  assign stat.out_free   = !m_tvalid || m_tready;

endmodule

// File: design/rectangle_raster_painter.sv
// Top level of the rectangle raster painter: joins the controller and the
// datapath. Depends on rrp_pkg, rrp_ctrl and rrp_datapath.
//
//   channel   dir  signals                            contents
//   request   in   s_tvalid s_tready s_tdata s_tuser  clear, draw or read
//   result    out  m_tvalid m_tready m_tdata          status and pixel
//   config    in   cfg_we cfg_index cfg_data          canvas size, background
//
// A clear or a valid draw on a non-empty canvas sweeps every pixel between
// accept and result: the pixel store has one write port and the sweep visits
// one pixel per cycle. A read, a bad draw or an unused kind skips the sweep.
// One request is worked at a time; the next is accepted once the result is
// handed to the output register, which holds it while m_tready is low.
// Reset clears control and the configuration registers; pixel contents are undefined until a clear.
module rectangle_raster_painter
  import rrp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // shape_type[7:0], rect_x[27:8], rect_y[47:28], rect_w[67:48],
  // rect_h[87:68], paint_char[95:88], read_row[103:96], read_col[111:104]
  input  logic [IN_W-1:0]      s_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]    s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // status[1:0], pixel[9:2], zero fill[15:10]
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  rrp_cmd_t  cmd;
  rrp_stat_t stat;

  rrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
